// ===== sv/integer_to_text_formatter_macros.svh =====
// Assertion macros for the checker file.
`ifndef INTEGER_TO_TEXT_FORMATTER_MACROS_SVH
`define INTEGER_TO_TEXT_FORMATTER_MACROS_SVH

// Concurrent check, switched off while reset is held.
`define ITF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent check that must hold during reset as well.
`define ITF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/itf_pkg.sv =====
`default_nettype none

package itf_pkg;

    localparam logic [2:0] KIND_SDEC = 3'd0;
    localparam logic [2:0] KIND_UDEC = 3'd1;
    localparam logic [2:0] KIND_HEXL = 3'd2;
    localparam logic [2:0] KIND_HEXU = 3'd3;
    localparam logic [2:0] KIND_ADDR = 3'd4;

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_LOWER = 8'd87;
    localparam logic [7:0] CHAR_UPPER = 8'd55;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] value;
    } itf_in_t;

    typedef struct packed {
        logic [7:0] character;
        logic [4:0] char_count;
        logic       last;
    } itf_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_STRIP,
        ST_SIGN,
        ST_EMIT
    } itf_state_t;

    function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
        logic [7:0] base;
        begin
            if (nib < 4'd10) begin
                base = CHAR_ZERO;
            end else if (upper) begin
                base = CHAR_UPPER;
            end else begin
                base = CHAR_LOWER;
            end
            digit_char = base + {4'd0, nib};
        end
    endfunction

endpackage

`default_nettype wire

// ===== sv/integer_to_text_formatter.sv =====
// Channel  | Ports                        | Direction | Word
// input    | s_valid s_ready s_payload    | in        | kind, value
// result   | m_valid m_ready m_payload    | out       | character, char_count, last
//
// A word is taken only when idle; the block stays busy until its last character is loaded.
// Decimal kinds: a load step, 32 shift-and-add-3 steps, leading-zero stripping down to at
// least one digit, a sign step for a negative signed value, then one digit per cycle unstalled.
// Hex kinds: a load step, leading-zero stripping of the 8 (32-bit) or 16 (address) digits,
// then one digit per cycle unstalled. A kind above 4 is taken but gives no output.
// Reset is synchronous and active low; a stalled output holds the sign and digit steps.
`default_nettype none

module integer_to_text_formatter
    import itf_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire itf_in_t  s_payload,
    output logic          m_valid,
    input  wire logic     m_ready,
    output itf_out_t      m_payload
);

    itf_state_t  state_reg, state_next;
    logic [63:0] dig_reg, dig_next;
    logic [31:0] bin_reg, bin_next;
    logic [4:0]  step_reg, step_next;
    logic [4:0]  ndig_reg, ndig_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        upper_reg, upper_next;
    logic        m_valid_reg, m_valid_next;
    itf_out_t    out_reg, out_next;

    logic        accept;
    logic        slot_free;
    logic        top_zero;
    logic [31:0] low_word;
    logic [31:0] magnitude;
    logic [39:0] bcd_adj;

    assign accept    = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;
    assign top_zero  = (dig_reg[63:60] == 4'd0);
    assign low_word  = s_payload.value[31:0];
    assign magnitude = low_word[31] ? (~low_word + 32'd1) : low_word;

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

    // Add three to every BCD digit of five or more ahead of the shift.
    always_comb begin
        for (int i = 0; i < 10; i++) begin
            if (dig_reg[24 + 4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = dig_reg[24 + 4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = dig_reg[24 + 4*i +: 4];
            end
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_payload.kind)
                        KIND_SDEC, KIND_UDEC:           state_next = ST_CONV;
                        KIND_HEXL, KIND_HEXU, KIND_ADDR: state_next = ST_STRIP;
                        default:                        state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CONV: begin
                if (step_reg == 5'd31) begin
                    state_next = ST_STRIP;
                end
            end
            ST_STRIP: begin
                if (!(ndig_reg > 5'd1 && top_zero)) begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (slot_free) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free && ndig_reg == 5'd1) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and output register.
    always_comb begin
        dig_next     = dig_reg;
        bin_next     = bin_reg;
        step_next    = step_reg;
        ndig_next    = ndig_reg;
        cnt_next     = cnt_reg;
        neg_next     = neg_reg;
        upper_next   = upper_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    step_next  = 5'd0;
                    cnt_next   = 5'd0;
                    neg_next   = 1'b0;
                    upper_next = (s_payload.kind == KIND_HEXU);
                    unique case (s_payload.kind)
                        KIND_SDEC: begin
                            bin_next  = magnitude;
                            neg_next  = low_word[31];
                            dig_next  = 64'd0;
                            ndig_next = 5'd10;
                        end
                        KIND_UDEC: begin
                            bin_next  = low_word;
                            dig_next  = 64'd0;
                            ndig_next = 5'd10;
                        end
                        KIND_HEXL, KIND_HEXU: begin
                            dig_next  = {low_word, 32'd0};
                            ndig_next = 5'd8;
                        end
                        KIND_ADDR: begin
                            dig_next  = s_payload.value;
                            ndig_next = 5'd16;
                        end
                        default: begin
                            ndig_next = ndig_reg;
                        end
                    endcase
                end
            end
            ST_CONV: begin
                dig_next  = {bcd_adj[38:0], bin_reg[31], 24'd0};
                bin_next  = {bin_reg[30:0], 1'b0};
                step_next = step_reg + 5'd1;
            end
            ST_STRIP: begin
                if (ndig_reg > 5'd1 && top_zero) begin
                    dig_next  = {dig_reg[59:0], 4'd0};
                    ndig_next = ndig_reg - 5'd1;
                end
            end
            ST_SIGN: begin
                if (slot_free) begin
                    out_next.character  = CHAR_MINUS;
                    out_next.char_count = 5'd1;
                    out_next.last       = 1'b0;
                    m_valid_next        = 1'b1;
                    cnt_next            = 5'd1;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    out_next.character  = digit_char(dig_reg[63:60], upper_reg);
                    out_next.char_count = cnt_reg + 5'd1;
                    out_next.last       = (ndig_reg == 5'd1);
                    m_valid_next        = 1'b1;
                    cnt_next            = cnt_reg + 5'd1;
                    dig_next            = {dig_reg[59:0], 4'd0};
                    ndig_next           = ndig_reg - 5'd1;
                end
            end
            default: begin
                m_valid_next = m_valid_reg && !m_ready;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dig_reg   <= dig_next;
        bin_reg   <= bin_next;
        step_reg  <= step_next;
        ndig_reg  <= ndig_next;
        cnt_reg   <= cnt_next;
        neg_reg   <= neg_next;
        upper_reg <= upper_next;
        out_reg   <= out_next;
    end

endmodule

`default_nettype wire

// ===== sv/itf_checker.sv =====
`default_nettype none
`include "integer_to_text_formatter_macros.svh"

module itf_checker
    import itf_pkg::*;
(
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_valid,
    input wire logic     s_ready,
    input wire itf_in_t  s_payload,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire itf_out_t m_payload
);

    // A stalled result word must hold.
    `ITF_ASSERT(a_out_hold, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_payload)), "result word changed while stalled")

    // The running count always lies within one to sixteen.
    `ITF_ASSERT(a_count_range, aclk, aresetn, m_valid |-> (m_payload.char_count != 5'd0 && m_payload.char_count <= 5'd16), "character count out of range")

    // A minus sign only ever opens a run.
    `ITF_ASSERT(a_minus_first, aclk, aresetn, (m_valid && m_payload.character == CHAR_MINUS) |-> (m_payload.char_count == 5'd1 && !m_payload.last), "minus sign not first")

    // While the output register holds a character other than the last, no new word is taken.
    `ITF_ASSERT(a_busy_in_run, aclk, aresetn, (m_valid && !m_payload.last) |-> !s_ready, "input ready in the middle of a run")

    // A valid kind makes the block busy on the next cycle.
    `ITF_ASSERT(a_busy_after_take, aclk, aresetn, (s_valid && s_ready && s_payload.kind <= KIND_ADDR) |=> !s_ready, "input ready straight after taking a word")

endmodule

bind integer_to_text_formatter itf_checker u_itf_checker (.*);

`default_nettype wire
